/* design/rfae_pkg.sv */
// Shared types and constants for the register file ALU executor.
package rfae_pkg;

  localparam int unsigned FieldIdxBits = 3;
  localparam int unsigned ImmBits      = 32;
  localparam int unsigned ValueBits    = 32;

  typedef enum logic [2:0] {
    OP_CMOV  = 3'd0,
    OP_ADD   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_NAND  = 3'd4,
    OP_LOADI = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ITER,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         dest_reg;
    logic [2:0]         src_b;
    logic [2:0]         src_c;
    logic [ImmBits-1:0] immediate;
  } in_req_t;

  typedef struct packed {
    logic                 wrote;
    logic [2:0]           written_reg;
    logic [ValueBits-1:0] written_value;
    logic                 div_by_zero;
  } out_req_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic iterative;
    logic last_step;
    logic out_free;
  } dp_status_t;

endpackage

/* design/rfae_ram.sv */
// Generic RAM with one write port and two registered read ports.
module rfae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* design/rfae_ctrl.sv */
// Controller state machine that sequences one instruction at a time.
module rfae_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rfae_pkg::dp_status_t   status_i,
  output rfae_pkg::ctrl_cmd_t    cmd_o
);

  rfae_pkg::ctrl_state_e state_q;
  rfae_pkg::ctrl_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfae_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      rfae_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rfae_pkg::ST_READ;
        end
      end
      rfae_pkg::ST_READ: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.iterative ? rfae_pkg::ST_ITER : rfae_pkg::ST_DONE;
      end
      rfae_pkg::ST_ITER: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = rfae_pkg::ST_DONE;
        end
      end
      rfae_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = rfae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rfae_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/rfae_dpath.sv */
// Datapath: register file, valid bits, shared multiply/divide unit and result register.
module rfae_dpath #(
  parameter int unsigned REG_COUNT = 8,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rfae_pkg::ctrl_cmd_t  cmd_i,
  output rfae_pkg::dp_status_t status_o,
  input  rfae_pkg::in_req_t    in_req_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output rfae_pkg::out_req_t   out_req_o
);

  localparam int unsigned IdxW = $clog2(REG_COUNT);
  localparam int unsigned CntW = $clog2(WORD_BITS + 1);

  // Field indexes wrap modulo the register count by repeated subtraction.
  function automatic logic [2:0] wrap_idx(input logic [2:0] field);
    logic [4:0] v;
    v = {2'b00, field};
    for (int k = 0; k < 4; k++) begin
      if (v >= 5'(REG_COUNT)) begin
        v = v - 5'(REG_COUNT);
      end
    end
    return v[2:0];
  endfunction

  rfae_pkg::op_e                 op_q;
  logic [2:0]                    ra_q;
  logic [rfae_pkg::ImmBits-1:0]  imm_q;
  logic                          b_ok_q;
  logic                          c_ok_q;
  logic [WORD_BITS-1:0]          acc_q;
  logic [WORD_BITS-1:0]          opa_q;
  logic [WORD_BITS-1:0]          opb_q;
  logic [WORD_BITS-1:0]          res_q;
  logic                          wr_q;
  logic                          dz_q;
  logic [CntW-1:0]               cnt_q;
  logic [REG_COUNT-1:0]          valid_q;
  logic                          out_valid_q;
  rfae_pkg::out_req_t            out_q;

  logic [IdxW-1:0]      ib;
  logic [IdxW-1:0]      ic;
  logic [IdxW-1:0]      ia;
  logic [WORD_BITS-1:0] rd_b;
  logic [WORD_BITS-1:0] rd_c;
  logic [WORD_BITS-1:0] vb;
  logic [WORD_BITS-1:0] vc;
  logic [WORD_BITS-1:0] exec_val;
  logic                 exec_wr;
  logic                 exec_dz;
  logic                 is_mul;
  logic [WORD_BITS-1:0] mul_acc_next;
  logic [WORD_BITS:0]   div_shift;
  logic [WORD_BITS:0]   div_trial;
  logic                 div_fits;
  logic [WORD_BITS-1:0] div_rem_next;
  logic [WORD_BITS-1:0] div_quo_next;
  logic                 out_free;

  assign ib = IdxW'(wrap_idx(in_req_i.src_b));
  assign ic = IdxW'(wrap_idx(in_req_i.src_c));
  assign ia = IdxW'(ra_q);

  rfae_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (REG_COUNT)
  ) u_regs (
    .clk_i     (clk_i),
    .we_i      (cmd_i.commit && wr_q),
    .waddr_i   (ia),
    .wdata_i   (res_q),
    .re_i      (cmd_i.load),
    .raddr_a_i (ib),
    .raddr_b_i (ic),
    .rdata_a_o (rd_b),
    .rdata_b_o (rd_c)
  );

  // Entries never written since reset read as zero.
  assign vb = b_ok_q ? rd_b : '0;
  assign vc = c_ok_q ? rd_c : '0;

  always_comb begin
    exec_val = '0;
    exec_wr  = 1'b0;
    exec_dz  = 1'b0;
    case (op_q)
      rfae_pkg::OP_CMOV: begin
        exec_wr  = (vc != '0);
        exec_val = vb;
      end
      rfae_pkg::OP_ADD: begin
        exec_wr  = 1'b1;
        exec_val = vb + vc;
      end
      rfae_pkg::OP_MUL: begin
        exec_wr = 1'b1;
      end
      rfae_pkg::OP_DIV: begin
        exec_dz = (vc == '0);
        exec_wr = (vc != '0);
      end
      rfae_pkg::OP_NAND: begin
        exec_wr  = 1'b1;
        exec_val = ~(vb & vc);
      end
      rfae_pkg::OP_LOADI: begin
        exec_wr  = 1'b1;
        exec_val = WORD_BITS'(imm_q);
      end
      default: begin
        exec_wr = 1'b0;
      end
    endcase
  end

  // One multiplier bit or one quotient bit per step.
  assign is_mul       = (op_q == rfae_pkg::OP_MUL);
  assign mul_acc_next = opb_q[0] ? acc_q + opa_q : acc_q;
  assign div_shift    = {acc_q, opa_q[WORD_BITS-1]};
  assign div_trial    = div_shift - {1'b0, opb_q};
  assign div_fits     = (div_shift >= {1'b0, opb_q});
  assign div_rem_next = div_fits ? div_trial[WORD_BITS-1:0] : div_shift[WORD_BITS-1:0];
  assign div_quo_next = {opa_q[WORD_BITS-2:0], div_fits};

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.iterative = is_mul || ((op_q == rfae_pkg::OP_DIV) && (vc != '0));
  assign status_o.last_step = (cnt_q == CntW'(1));
  assign status_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.commit && wr_q) begin
        valid_q[ia] <= 1'b1;
      end
      out_valid_q <= cmd_i.commit || (out_valid_q && out_stall_i);
      if (cmd_i.exec) begin
        cnt_q <= CntW'(WORD_BITS);
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= rfae_pkg::op_e'(in_req_i.operation);
      ra_q   <= wrap_idx(in_req_i.dest_reg);
      imm_q  <= in_req_i.immediate;
      b_ok_q <= valid_q[ib];
      c_ok_q <= valid_q[ic];
    end
    if (cmd_i.exec) begin
      res_q <= exec_val;
      wr_q  <= exec_wr;
      dz_q  <= exec_dz;
      if (is_mul) begin
        acc_q <= '0;
        opa_q <= vb;
        opb_q <= vc;
      end else begin
        acc_q <= '0;
        opa_q <= vb;
        opb_q <= vc;
      end
    end else if (cmd_i.step) begin
      if (is_mul) begin
        acc_q <= mul_acc_next;
        opa_q <= opa_q << 1;
        opb_q <= opb_q >> 1;
        if (status_o.last_step) begin
          res_q <= mul_acc_next;
        end
      end else begin
        acc_q <= div_rem_next;
        opa_q <= div_quo_next;
        if (status_o.last_step) begin
          res_q <= div_quo_next;
        end
      end
    end
    if (cmd_i.commit) begin
      out_q.wrote         <= wr_q;
      out_q.written_reg   <= wr_q ? ra_q : '0;
      out_q.written_value <= wr_q ? rfae_pkg::ValueBits'(res_q) : '0;
      out_q.div_by_zero   <= dz_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* design/register_file_alu_executor_top.sv */
// Top level of the register file ALU executor: controller, datapath and checks.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid_i/in_stall_o  | in_req_i (instruction)
//   out     | output    | out_valid_o/out_stall_i| out_req_o (write report)
//
// An instruction passes through accept, register read and commit for conditional
// move, add, nand, load immediate, the unused codes and a divide by zero.
// Multiply and divide also pass through the iterate state of the shared
// shift-and-add / restoring divide unit, which retires one bit per cycle.
// Reset clears the controller, the output valid flag and the per-register valid
// bits, so every register reads as zero until written; no clearing pass runs.
// The result register lets the next request enter while the last result is
// still stalled; a finished result waits in the commit state only when the
// result register is still full and stalled.
module register_file_alu_executor_top #(
  parameter int unsigned REG_COUNT = 8,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rfae_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rfae_pkg::out_req_t out_req_o
);

  // Commands flow from the controller to the datapath, status flows back.
  rfae_pkg::ctrl_cmd_t  cmd;
  rfae_pkg::dp_status_t status;

  // The controller owns the input handshake and the sequencing of each request.
  rfae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the register file, the iterative unit and the result register.
  rfae_dpath #(
    .REG_COUNT (REG_COUNT),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

`ifndef NO_ASSERTIONS
  // Only one request is in flight: the port closes right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a request was in flight");

  // A commit always presents its result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  // A divide by zero never reports a register write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.div_by_zero) |-> !out_req_o.wrote)
    else $error("divide by zero reported a write");

  // A result without a write carries zero index and value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.wrote) |->
      (out_req_o.written_reg == '0) && (out_req_o.written_value == '0))
    else $error("no-write result carries nonzero fields");
`endif

endmodule

/* dv/tb_register_file_alu_executor_top.sv */
// Self-checking testbench for the register file ALU executor top level.
`timescale 1ns / 1ps

module tb_register_file_alu_executor_top;

  // The package names only the six defined operations. The two spare codes
  // must still be driven, and they have to leave the register file alone.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int unsigned RegCount    = 8;
  localparam int unsigned MaxWait     = 14;
  // The limit sits well above the slowest correct run of about 625 requests,
  // counting multiply and divide and the longest idle waits on the input
  // and the longest stalls on the output.
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned DrainCycles = 100;

  // Idling styles: none, uniform over 0..MaxWait, and mostly long waits.
  localparam int unsigned IdleNone  = 0;
  localparam int unsigned IdleRand  = 1;
  localparam int unsigned IdleHeavy = 2;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  rfae_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  rfae_pkg::out_req_t out_req_o;

  // Shadow copy of the architectural registers, updated when a request is
  // accepted. Results come back in order, so a plain FIFO of predicted
  // write reports is enough.
  logic [rfae_pkg::ValueBits-1:0] arch_regs [RegCount];
  rfae_pkg::out_req_t             expected_writes[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned in_idle_mode;
  int unsigned out_idle_mode;
  int unsigned out_hold_cycles;

  register_file_alu_executor_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // 12 ns clock: six high, six low.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog. A hang anywhere in the block ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("register_file_alu_executor_top: mismatch");
      $finish;
    end
  end

  // Returns how many cycles one side waits before its next request.
  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      IdleNone: return 0;
      IdleHeavy: return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, MaxWait);
      default: return $urandom_range(0, MaxWait);
    endcase
  endfunction

  // Executes one instruction against the shadow registers and returns the
  // write report that the block must produce for it.
  function automatic rfae_pkg::out_req_t execute_instr(rfae_pkg::in_req_t instr);
    logic [rfae_pkg::ValueBits-1:0] val_b;
    logic [rfae_pkg::ValueBits-1:0] val_c;
    logic [rfae_pkg::ValueBits-1:0] result;
    logic                           wr;
    logic                           dz;
    rfae_pkg::out_req_t             report;
    val_b  = arch_regs[3'(instr.src_b % RegCount)];
    val_c  = arch_regs[3'(instr.src_c % RegCount)];
    result = '0;
    wr     = 1'b0;
    dz     = 1'b0;
    case (instr.operation)
      rfae_pkg::OP_CMOV: begin
        if (val_c != '0) begin
          result = val_b;
          wr     = 1'b1;
        end
      end
      rfae_pkg::OP_ADD: begin
        result = val_b + val_c;
        wr     = 1'b1;
      end
      rfae_pkg::OP_MUL: begin
        result = val_b * val_c;
        wr     = 1'b1;
      end
      rfae_pkg::OP_DIV: begin
        if (val_c == '0) begin
          dz = 1'b1;
        end else begin
          result = val_b / val_c;
          wr     = 1'b1;
        end
      end
      rfae_pkg::OP_NAND: begin
        result = ~(val_b & val_c);
        wr     = 1'b1;
      end
      rfae_pkg::OP_LOADI: begin
        result = instr.immediate;
        wr     = 1'b1;
      end
      default: begin
      end
    endcase
    if (wr) begin
      arch_regs[3'(instr.dest_reg % RegCount)] = result;
    end
    report.wrote         = wr;
    report.written_reg   = wr ? instr.dest_reg : '0;
    report.written_value = wr ? result : '0;
    report.div_by_zero   = dz;
    return report;
  endfunction

  function automatic rfae_pkg::in_req_t make_instr(logic [2:0] op, logic [2:0] a,
                                                   logic [2:0] b, logic [2:0] c,
                                                   logic [rfae_pkg::ImmBits-1:0] imm);
    rfae_pkg::in_req_t instr;
    instr.operation = op;
    instr.dest_reg  = a;
    instr.src_b     = b;
    instr.src_c     = c;
    instr.immediate = imm;
    return instr;
  endfunction

  // Random instruction. Loads are frequent enough to keep fresh values in
  // the file, and a share of them carry zero, all ones or small numbers so
  // that divides see zero divisors and nontrivial quotients.
  function automatic rfae_pkg::in_req_t random_instr();
    int unsigned                  roll;
    logic [2:0]                   op;
    logic [rfae_pkg::ImmBits-1:0] imm;
    roll = $urandom_range(0, 99);
    if (roll < 20)      op = rfae_pkg::OP_LOADI;
    else if (roll < 32) op = rfae_pkg::OP_CMOV;
    else if (roll < 46) op = rfae_pkg::OP_ADD;
    else if (roll < 58) op = rfae_pkg::OP_MUL;
    else if (roll < 74) op = rfae_pkg::OP_DIV;
    else if (roll < 94) op = rfae_pkg::OP_NAND;
    else if (roll < 97) op = OP_SPARE6;
    else                op = OP_SPARE7;
    case ($urandom_range(0, 7))
      0: imm = '0;
      1: imm = '1;
      2: imm = $urandom_range(0, 15);
      default: imm = $urandom;
    endcase
    return make_instr(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), imm);
  endfunction

  task automatic report_mismatch(string what, logic [rfae_pkg::ValueBits-1:0] got,
                                 logic [rfae_pkg::ValueBits-1:0] want);
    $display("%0t ns: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Sends one request. Valid goes low only when there is a gap, so a
  // back-to-back request keeps valid high through the falling edge.
  task automatic send_instr(rfae_pkg::in_req_t instr);
    int unsigned gap;
    gap = draw_wait(in_idle_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= instr;
    // Sampled right after the edge, before the block's registers update.
    do @(posedge clk_i); while (in_stall_o);
    expected_writes.push_back(execute_instr(instr));
  endtask

  // Output side: stall for the drawn number of cycles before each result.
  always @(negedge clk_i) begin
    if (out_hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      out_hold_cycles--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker. Every accepted result is compared with the oldest
  // pending prediction, one field at a time.
  always @(posedge clk_i) begin
    rfae_pkg::out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("result with no request pending", out_req_o.written_value, '0);
      end else begin
        want = expected_writes.pop_front();
        if (out_req_o.wrote !== want.wrote)
          report_mismatch("wrote", 32'(out_req_o.wrote), 32'(want.wrote));
        if (out_req_o.written_reg !== want.written_reg)
          report_mismatch("written_reg", 32'(out_req_o.written_reg),
                          32'(want.written_reg));
        if (out_req_o.written_value !== want.written_value)
          report_mismatch("written_value", out_req_o.written_value, want.written_value);
        if (out_req_o.div_by_zero !== want.div_by_zero)
          report_mismatch("div_by_zero", 32'(out_req_o.div_by_zero),
                          32'(want.div_by_zero));
      end
      out_hold_cycles = draw_wait(out_idle_mode);
    end
  end

  // Hand-picked instructions. The file is all zeros after reset, so the
  // first two hit a false condition and a zero divisor without any setup.
  // After that come extreme values, wraparound in add and multiply,
  // quotients at the edges, nand of all ones and all zeros, the spare
  // codes, and a destination that is also a source.
  task automatic test_directed_cases();
    send_instr(make_instr(rfae_pkg::OP_CMOV,  3'd0, 3'd1, 3'd2, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_DIV,   3'd3, 3'd4, 3'd5, 32'hFFFF_FFFF));
    send_instr(make_instr(rfae_pkg::OP_LOADI, 3'd7, 3'd0, 3'd0, 32'hFFFF_FFFF));
    send_instr(make_instr(rfae_pkg::OP_LOADI, 3'd0, 3'd7, 3'd7, 32'h0000_0000));
    send_instr(make_instr(rfae_pkg::OP_LOADI, 3'd1, 3'd0, 3'd0, 32'h8000_0000));
    send_instr(make_instr(rfae_pkg::OP_LOADI, 3'd2, 3'd0, 3'd0, 32'h0000_0001));
    send_instr(make_instr(rfae_pkg::OP_LOADI, 3'd6, 3'd0, 3'd0, 32'h1234_5678));
    send_instr(make_instr(rfae_pkg::OP_CMOV,  3'd3, 3'd7, 3'd2, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_CMOV,  3'd4, 3'd7, 3'd0, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_ADD,   3'd5, 3'd7, 3'd2, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_ADD,   3'd4, 3'd7, 3'd7, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_MUL,   3'd5, 3'd7, 3'd7, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_MUL,   3'd4, 3'd1, 3'd1, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_MUL,   3'd3, 3'd6, 3'd7, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_DIV,   3'd5, 3'd7, 3'd2, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_DIV,   3'd4, 3'd2, 3'd7, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_DIV,   3'd3, 3'd7, 3'd7, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_DIV,   3'd3, 3'd6, 3'd0, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_DIV,   3'd5, 3'd7, 3'd6, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_NAND,  3'd5, 3'd7, 3'd7, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_NAND,  3'd4, 3'd0, 3'd0, 32'h0));
    send_instr(make_instr(rfae_pkg::OP_NAND,  3'd6, 3'd6, 3'd6, 32'h0));
    send_instr(make_instr(OP_SPARE6,          3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF));
    send_instr(make_instr(OP_SPARE7,          3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF));
    send_instr(make_instr(rfae_pkg::OP_ADD,   3'd0, 3'd0, 3'd7, 32'h0));
  endtask

  // Random programs with random gaps on both sides.
  task automatic test_random_program(int unsigned count);
    repeat (count) send_instr(random_instr());
  endtask

  // No idling at all: requests arrive back to back and results are taken
  // as soon as they appear, which exercises the full rate of the block.
  task automatic test_back_to_back(int unsigned count);
    in_idle_mode  = IdleNone;
    out_idle_mode = IdleNone;
    repeat (count) send_instr(random_instr());
  endtask

  // A fast sender against a slow receiver, so requests pile up behind a
  // full result register and the input stall has to hold them off.
  task automatic test_output_backpressure(int unsigned count);
    in_idle_mode  = IdleNone;
    out_idle_mode = IdleHeavy;
    repeat (count) send_instr(random_instr());
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_req_i        = '0;
    out_stall_i     = 1'b0;
    out_hold_cycles = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    in_idle_mode    = IdleRand;
    out_idle_mode   = IdleRand;
    for (int i = 0; i < RegCount; i++) begin
      arch_regs[i] = '0;
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_program(200);
    test_back_to_back(150);
    test_output_backpressure(150);
    in_idle_mode  = IdleHeavy;
    out_idle_mode = IdleRand;
    test_random_program(100);

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait for every predicted result, then a little longer so that a
    // spurious extra result would still be caught.
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("register_file_alu_executor_top: match");
    end else begin
      $display("register_file_alu_executor_top: mismatch");
    end
    $finish;
  end

endmodule
